// ===== rtl/lsm_append_buffer_core_defines.svh =====
// Assertion macros shared by the checker of the append buffer core
`ifndef LSM_APPEND_BUFFER_CORE_DEFINES_SVH
`define LSM_APPEND_BUFFER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LSMAB_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsmab assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define LSMAB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsmab assertion failed");

`endif

// ===== rtl/lsmab_pkg.sv =====
// Types and codes shared by the append buffer controller and datapath
`default_nettype none
package lsmab_pkg;

	localparam logic [2:0] OP_PUT   = 3'd0;
	localparam logic [2:0] OP_DEL   = 3'd1;
	localparam logic [2:0] OP_GET   = 3'd2;
	localparam logic [2:0] OP_FLUSH = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_ABSENT  = 3'd2;
	localparam logic [2:0] ST_DELETED = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	typedef enum logic [2:0] {
		RS_OK     = 3'd0,
		RS_FULL   = 3'd1,
		RS_ABSENT = 3'd2,
		RS_EMPTY  = 3'd3,
		RS_GET    = 3'd4,
		RS_FLUSH  = 3'd5
	} rsel_t;

	typedef struct packed {
		logic  cap_in;
		logic  append;
		logic  clear;
		logic  get_init;
		logic  flush_init;
		logic  rd;
		logic  get_step;
		logic  fl_step;
		logic  pass_end;
		logic  finish;
		logic  out_load;
		rsel_t rsel;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       full;
		logic       empty;
		logic       hit;
		logic       get_last;
		logic       fl_last;
		logic       have_best;
		logic       have_pend;
		logic       out_take;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/lsm_append_buffer_core.sv =====
// Top level of the LSM append buffer: controller plus datapath
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  operation, key, value
//   out      source     out_valid/out_stall  status, out_key, out_value, tombstone, last
//   cfg      sink       cfg_we               cfg_wdata (capacity)
//
// A get scans the entries from newest to oldest and stops at the first key match.
// A flush runs one selection pass over the n stored entries per surviving key plus a
// closing pass, reading one entry at a time through the single read port.
// Reset empties the store and sets capacity to 64; no clearing pass is needed.
// A stalled output word holds, and so does all work on the item behind it.
`default_nettype none
module lsm_append_buffer_core #(
	parameter int DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         operation,
	input  wire logic signed [31:0] key,
	input  wire logic signed [31:0] value,
	input  wire logic               cfg_we,
	input  wire logic [6:0]         cfg_wdata,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic signed [31:0]      out_key,
	output logic signed [31:0]      out_value,
	output logic                    tombstone,
	output logic                    last
);
	lsmab_pkg::cmd_t cmd;
	lsmab_pkg::sts_t sts;

	lsmab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lsmab_dp #(.DEPTH(DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.operation (operation),
		.key       (key),
		.value     (value),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.status    (status),
		.out_key   (out_key),
		.out_value (out_value),
		.tombstone (tombstone),
		.last      (last)
	);
endmodule
`default_nettype wire

// ===== rtl/lsmab_dp.sv =====
// Datapath of the append buffer: entry memory, scan registers, output word
`default_nettype none
module lsmab_dp #(
	parameter int DEPTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lsmab_pkg::cmd_t   cmd,
	output lsmab_pkg::sts_t        sts,
	input  wire logic [2:0]        operation,
	input  wire logic signed [31:0] key,
	input  wire logic signed [31:0] value,
	input  wire logic              cfg_we,
	input  wire logic [6:0]        cfg_wdata,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output logic [2:0]             status,
	output logic signed [31:0]     out_key,
	output logic signed [31:0]     out_value,
	output logic                   tombstone,
	output logic                   last
);
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = IW + 1;
	localparam int MD = 2 * DEPTH;

	logic [31:0] mem_key [MD];
	logic [31:0] mem_val [MD];
	logic        mem_dead [MD];

	logic [2:0]  op_q;
	logic [31:0] key_q, val_q;
	logic [CW-1:0] count_q, oidx_q;
	logic        bank_q;
	logic [IW-1:0] idx_q;
	logic [6:0]  cap_q;
	logic [31:0] prev_key_q, best_key_q, best_val_q, pend_key_q, pend_val_q;
	logic        best_dead_q, pend_dead_q;
	logic        have_prev_q, have_best_q, have_pend_q;
	logic [31:0] rd_key_q, rd_val_q;
	logic        rd_dead_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_key, wr_val;
	logic          wr_dead;
	logic          qual, better;

	always_comb begin
		wr_en   = cmd.append | cmd.pass_end;
		if (cmd.append) begin
			wr_addr = {bank_q, count_q[IW-1:0]};
			wr_key  = key_q;
			wr_val  = (op_q == lsmab_pkg::OP_PUT) ? val_q : 32'd0;
			wr_dead = (op_q == lsmab_pkg::OP_DEL);
		end else begin
			wr_addr = {~bank_q, oidx_q[IW-1:0]};
			wr_key  = best_key_q;
			wr_val  = best_val_q;
			wr_dead = best_dead_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_key[wr_addr]  <= wr_key;
			mem_val[wr_addr]  <= wr_val;
			mem_dead[wr_addr] <= wr_dead;
		end
		if (cmd.rd) begin
			rd_key_q  <= mem_key[{bank_q, idx_q}];
			rd_val_q  <= mem_val[{bank_q, idx_q}];
			rd_dead_q <= mem_dead[{bank_q, idx_q}];
		end
	end

	assign qual   = !have_prev_q || ($signed(rd_key_q) > $signed(prev_key_q));
	assign better = !have_best_q || ($signed(rd_key_q) <= $signed(best_key_q));

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			op_q  <= operation;
			key_q <= key;
			val_q <= value;
		end
		if (cmd.fl_step && qual && better) begin
			best_key_q  <= rd_key_q;
			best_val_q  <= rd_val_q;
			best_dead_q <= rd_dead_q;
		end
		if (cmd.pass_end) begin
			pend_key_q  <= best_key_q;
			pend_val_q  <= best_val_q;
			pend_dead_q <= best_dead_q;
			prev_key_q  <= best_key_q;
		end
		if (cmd.get_init)
			idx_q <= IW'(count_q - 1'b1);
		else if (cmd.flush_init || cmd.pass_end)
			idx_q <= '0;
		else if (cmd.get_step)
			idx_q <= idx_q - 1'b1;
		else if (cmd.fl_step)
			idx_q <= idx_q + 1'b1;
		if (cmd.out_load) begin
			status    <= lsmab_pkg::ST_OK;
			out_key   <= key_q;
			out_value <= '0;
			tombstone <= 1'b0;
			last      <= 1'b1;
			unique case (cmd.rsel)
				lsmab_pkg::RS_OK: ;
				lsmab_pkg::RS_FULL:   status <= lsmab_pkg::ST_FULL;
				lsmab_pkg::RS_ABSENT: status <= lsmab_pkg::ST_ABSENT;
				lsmab_pkg::RS_EMPTY:  status <= lsmab_pkg::ST_EMPTY;
				lsmab_pkg::RS_GET: begin
					status    <= rd_dead_q ? lsmab_pkg::ST_DELETED : lsmab_pkg::ST_OK;
					out_value <= rd_dead_q ? 32'd0 : rd_val_q;
				end
				lsmab_pkg::RS_FLUSH: begin
					out_key   <= pend_key_q;
					out_value <= pend_dead_q ? 32'd0 : pend_val_q;
					tombstone <= pend_dead_q;
					last      <= !have_best_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			oidx_q      <= '0;
			bank_q      <= 1'b0;
			cap_q       <= 7'd64;
			have_prev_q <= 1'b0;
			have_best_q <= 1'b0;
			have_pend_q <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (cfg_we)
				cap_q <= cfg_wdata;
			if (cmd.append)
				count_q <= count_q + 1'b1;
			else if (cmd.clear)
				count_q <= '0;
			else if (cmd.finish)
				count_q <= oidx_q;
			if (cmd.finish)
				bank_q <= ~bank_q;
			if (cmd.flush_init) begin
				oidx_q      <= '0;
				have_prev_q <= 1'b0;
				have_best_q <= 1'b0;
				have_pend_q <= 1'b0;
			end else if (cmd.pass_end) begin
				oidx_q      <= oidx_q + 1'b1;
				have_prev_q <= 1'b1;
				have_best_q <= 1'b0;
				have_pend_q <= 1'b1;
			end else if (cmd.fl_step && qual && better) begin
				have_best_q <= 1'b1;
			end
			if (cmd.out_load)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_comb begin
		sts.op        = op_q;
		sts.full      = (8'(count_q) >= 8'(DEPTH)) || (8'(count_q) >= 8'(cap_q));
		sts.empty     = (count_q == '0);
		sts.hit       = (rd_key_q == key_q);
		sts.get_last  = (idx_q == '0);
		sts.fl_last   = (idx_q == IW'(count_q - 1'b1));
		sts.have_best = have_best_q;
		sts.have_pend = have_pend_q;
		sts.out_take  = out_valid && !out_stall;
	end
endmodule
`default_nettype wire

// ===== rtl/lsmab_ctrl.sv =====
// Controller state machine of the append buffer
`default_nettype none
module lsmab_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire lsmab_pkg::sts_t sts,
	output lsmab_pkg::cmd_t      cmd
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_DISP  = 10'b0000000010,
		S_GRD   = 10'b0000000100,
		S_GCMP  = 10'b0000001000,
		S_FRD   = 10'b0000010000,
		S_FCMP  = 10'b0000100000,
		S_FEND  = 10'b0001000000,
		S_FWAIT = 10'b0010000000,
		S_FNEXT = 10'b0100000000,
		S_WAIT  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd      = '0;
		cmd.rsel = lsmab_pkg::RS_OK;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					state_d    = S_DISP;
				end
			end
			S_DISP: begin
				priority if (sts.op == lsmab_pkg::OP_PUT || sts.op == lsmab_pkg::OP_DEL) begin
					cmd.out_load = 1'b1;
					if (sts.full)
						cmd.rsel = lsmab_pkg::RS_FULL;
					else
						cmd.append = 1'b1;
					state_d = S_WAIT;
				end else if (sts.op == lsmab_pkg::OP_GET) begin
					if (sts.empty) begin
						cmd.out_load = 1'b1;
						cmd.rsel     = lsmab_pkg::RS_ABSENT;
						state_d      = S_WAIT;
					end else begin
						cmd.get_init = 1'b1;
						state_d      = S_GRD;
					end
				end else if (sts.op == lsmab_pkg::OP_FLUSH) begin
					if (sts.empty) begin
						cmd.out_load = 1'b1;
						cmd.rsel     = lsmab_pkg::RS_EMPTY;
						state_d      = S_WAIT;
					end else begin
						cmd.flush_init = 1'b1;
						state_d        = S_FRD;
					end
				end else if (sts.op == lsmab_pkg::OP_CLEAR) begin
					cmd.clear    = 1'b1;
					cmd.out_load = 1'b1;
					state_d      = S_WAIT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_GRD: begin
				cmd.rd  = 1'b1;
				state_d = S_GCMP;
			end
			S_GCMP: begin
				priority if (sts.hit) begin
					cmd.out_load = 1'b1;
					cmd.rsel     = lsmab_pkg::RS_GET;
					state_d      = S_WAIT;
				end else if (sts.get_last) begin
					cmd.out_load = 1'b1;
					cmd.rsel     = lsmab_pkg::RS_ABSENT;
					state_d      = S_WAIT;
				end else begin
					cmd.get_step = 1'b1;
					state_d      = S_GRD;
				end
			end
			S_FRD: begin
				cmd.rd  = 1'b1;
				state_d = S_FCMP;
			end
			S_FCMP: begin
				cmd.fl_step = 1'b1;
				state_d     = sts.fl_last ? S_FEND : S_FRD;
			end
			S_FEND: begin
				if (sts.have_pend) begin
					cmd.out_load = 1'b1;
					cmd.rsel     = lsmab_pkg::RS_FLUSH;
					state_d      = S_FWAIT;
				end else begin
					state_d = S_FNEXT;
				end
			end
			S_FWAIT: begin
				if (sts.out_take)
					state_d = S_FNEXT;
			end
			S_FNEXT: begin
				if (sts.have_best) begin
					cmd.pass_end = 1'b1;
					state_d      = S_FRD;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_WAIT: begin
				if (sts.out_take)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end
endmodule
`default_nettype wire

// ===== rtl/lsmab_checker.sv =====
// Port-level checker of the append buffer core and its bind
`default_nettype none
`include "lsm_append_buffer_core_defines.svh"
module lsmab_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic [2:0]         operation,
	input wire logic signed [31:0] key,
	input wire logic signed [31:0] value,
	input wire logic               cfg_we,
	input wire logic [6:0]         cfg_wdata,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [2:0]         status,
	input wire logic signed [31:0] out_key,
	input wire logic signed [31:0] out_value,
	input wire logic               tombstone,
	input wire logic               last
);
	`LSMAB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({status, out_key, last}))
	`LSMAB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`LSMAB_ASSERT_NOW(a_multi_only_ok, out_valid && (!last || tombstone), status == lsmab_pkg::ST_OK)
	`LSMAB_ASSERT_NOW(a_tomb_no_value, out_valid && tombstone, out_value == 32'sd0)
endmodule

bind lsm_append_buffer_core lsmab_checker u_lsmab_checker (.*);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the LSM append buffer core with a scoreboard class
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int CYCLE_LIMIT = 10000000;
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;

	typedef struct {
		logic [2:0]         st;
		logic signed [31:0] k;
		logic signed [31:0] v;
		logic               tomb;
		logic               lst;
	} result_t;

	class lsm_scoreboard;
		logic signed [31:0] keys[DEPTH];
		logic signed [31:0] vals[DEPTH];
		bit                 dead[DEPTH];
		int                 fill;
		logic [6:0]         cap;
		result_t            pending[$];
		int                 errors;

		function new();
			fill = 0;
			cap = 7'd64;
			errors = 0;
		endfunction

		function void push(logic [2:0] st, logic signed [31:0] k, logic signed [31:0] v,
				logic tomb, logic lst);
			result_t r;
			r.st = st; r.k = k; r.v = v; r.tomb = tomb; r.lst = lst;
			pending.push_back(r);
		endfunction

		function void note_word(logic [2:0] op, logic signed [31:0] k, logic signed [31:0] v);
			int lim, i, j;
			logic signed [31:0] tk, tv;
			bit td, found;
			lim = (cap < DEPTH) ? cap : DEPTH;
			case (op)
				lsmab_pkg::OP_PUT, lsmab_pkg::OP_DEL: begin
					if (fill >= lim) begin
						push(lsmab_pkg::ST_FULL, k, 32'sd0, 1'b0, 1'b1);
					end else begin
						keys[fill] = k;
						vals[fill] = (op == lsmab_pkg::OP_PUT) ? v : 32'sd0;
						dead[fill] = (op == lsmab_pkg::OP_DEL);
						fill++;
						push(lsmab_pkg::ST_OK, k, 32'sd0, 1'b0, 1'b1);
					end
				end
				lsmab_pkg::OP_GET: begin
					found = 0;
					for (i = fill - 1; i >= 0 && !found; i--) begin
						if (keys[i] == k) begin
							found = 1;
							if (dead[i]) push(lsmab_pkg::ST_DELETED, k, 32'sd0, 1'b0, 1'b1);
							else push(lsmab_pkg::ST_OK, k, vals[i], 1'b0, 1'b1);
						end
					end
					if (!found) push(lsmab_pkg::ST_ABSENT, k, 32'sd0, 1'b0, 1'b1);
				end
				lsmab_pkg::OP_FLUSH: begin
					if (fill == 0) begin
						push(lsmab_pkg::ST_EMPTY, k, 32'sd0, 1'b0, 1'b1);
					end else begin
						for (i = 1; i < fill; i++) begin
							tk = keys[i]; tv = vals[i]; td = dead[i];
							j = i;
							while (j > 0 && tk < keys[j-1]) begin
								keys[j] = keys[j-1]; vals[j] = vals[j-1]; dead[j] = dead[j-1];
								j--;
							end
							keys[j] = tk; vals[j] = tv; dead[j] = td;
						end
						j = 0;
						for (i = 1; i < fill; i++) begin
							if (keys[i] != keys[j]) j++;
							keys[j] = keys[i]; vals[j] = vals[i]; dead[j] = dead[i];
						end
						fill = j + 1;
						for (i = 0; i < fill; i++)
							push(lsmab_pkg::ST_OK, keys[i], dead[i] ? 32'sd0 : vals[i],
								dead[i], i + 1 == fill);
					end
				end
				lsmab_pkg::OP_CLEAR: begin
					fill = 0;
					push(lsmab_pkg::ST_OK, k, 32'sd0, 1'b0, 1'b1);
				end
				default: ;
			endcase
		endfunction

		function void check_word(result_t got);
			result_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word status=%0d key=%0d", $time, got.st, got.k);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.st !== e.st) begin
				$display("%0t: status exp %0d got %0d", $time, e.st, got.st);
				errors++;
			end
			if (got.k !== e.k) begin
				$display("%0t: out_key exp %0d got %0d", $time, e.k, got.k);
				errors++;
			end
			if (got.v !== e.v) begin
				$display("%0t: out_value exp %0d got %0d", $time, e.v, got.v);
				errors++;
			end
			if (got.tomb !== e.tomb) begin
				$display("%0t: tombstone exp %0d got %0d", $time, e.tomb, got.tomb);
				errors++;
			end
			if (got.lst !== e.lst) begin
				$display("%0t: last exp %0d got %0d", $time, e.lst, got.lst);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         operation = lsmab_pkg::OP_PUT;
	logic signed [31:0] key = '0;
	logic signed [31:0] value = '0;
	logic               cfg_we = 1'b0;
	logic [6:0]         cfg_wdata = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         status;
	logic signed [31:0] out_key;
	logic signed [31:0] out_value;
	logic               tombstone;
	logic               last;

	lsm_scoreboard sb = new();
	bit  calm = 0;
	int  cycles = 0;
	logic signed [31:0] key_pool[8];

	lsm_append_buffer_core #(.DEPTH(DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .key(key), .value(value),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .out_key(out_key), .out_value(out_value),
		.tombstone(tombstone), .last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_word(operation, key, value);
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.st = status; got.k = out_key; got.v = out_value;
			got.tomb = tombstone; got.lst = last;
			sb.check_word(got);
		end
	end

	always @(negedge clk)
		out_stall = !calm && ($urandom_range(0, 99) < 37);

	task automatic send_word(logic [2:0] op, logic signed [31:0] k, logic signed [31:0] v);
		while (!calm && $urandom_range(0, 99) < 37) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		operation = op;
		key = k;
		value = v;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_capacity(logic [6:0] c);
		drain();
		cfg_wdata = c;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.cap = c;
	endtask

	function automatic logic signed [31:0] pick_key();
		if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	task automatic random_words(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40) send_word(lsmab_pkg::OP_PUT, pick_key(), $urandom);
			else if (r < 55) send_word(lsmab_pkg::OP_DEL, pick_key(), $urandom);
			else if (r < 80) send_word(lsmab_pkg::OP_GET, pick_key(), $urandom);
			else if (r < 88) send_word(lsmab_pkg::OP_FLUSH, $urandom, $urandom);
			else if (r < 95) send_word(lsmab_pkg::OP_CLEAR, $urandom, $urandom);
			else send_word(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), $urandom, $urandom);
		end
	endtask

	initial begin
		key_pool = '{32'sh8000_0000, 32'sh7FFF_FFFF, 0, -1, 1, 5, -7, 32'sh1234_5678};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_word(lsmab_pkg::OP_FLUSH, 32'sh7FFF_FFFF, 0);
		send_word(lsmab_pkg::OP_PUT, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_word(lsmab_pkg::OP_PUT, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_word(lsmab_pkg::OP_PUT, 3, -1);
		send_word(lsmab_pkg::OP_DEL, 3, 99);
		send_word(lsmab_pkg::OP_GET, 3, 0);
		send_word(lsmab_pkg::OP_GET, 32'sh8000_0000, 0);
		send_word(lsmab_pkg::OP_GET, 42, 0);
		send_word(lsmab_pkg::OP_PUT, 32'sh8000_0000, 17);
		send_word(lsmab_pkg::OP_DEL, 9, 0);
		send_word(lsmab_pkg::OP_FLUSH, 0, 0);
		send_word(lsmab_pkg::OP_GET, 32'sh8000_0000, 0);
		send_word(lsmab_pkg::OP_GET, 3, 0);
		send_word(OP_UNUSED_LO, 1, 1);
		send_word(OP_UNUSED_HI, -1, -1);
		send_word(lsmab_pkg::OP_CLEAR, -1, 0);
		send_word(lsmab_pkg::OP_FLUSH, 32'sh8000_0000, 0);
		set_capacity(7'd1);
		send_word(lsmab_pkg::OP_PUT, 8, 8);
		send_word(lsmab_pkg::OP_PUT, 9, 9);
		send_word(lsmab_pkg::OP_DEL, 8, 0);
		set_capacity(7'd0);
		send_word(lsmab_pkg::OP_PUT, 1, 1);
		send_word(lsmab_pkg::OP_CLEAR, 0, 0);
		send_word(lsmab_pkg::OP_DEL, 1, 0);

		set_capacity(7'd127);
		for (int i = 0; i < DEPTH + 1; i++)
			send_word(($urandom_range(0, 3) == 0) ? lsmab_pkg::OP_DEL : lsmab_pkg::OP_PUT,
				$urandom, $urandom);
		send_word(lsmab_pkg::OP_FLUSH, 0, 0);
		send_word(lsmab_pkg::OP_CLEAR, 0, 0);

		set_capacity(7'd64);
		random_words(40);
		calm = 1;
		random_words(30);
		calm = 0;
		drain();
		set_capacity(7'($urandom_range(2, 12)));
		random_words(30);
		set_capacity(7'd3);
		random_words(20);
		set_capacity(7'd64);
		random_words(20);

		drain();
		repeat (100) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/lsmab_pkg.sv
rtl/lsmab_dp.sv
rtl/lsmab_ctrl.sv
rtl/lsm_append_buffer_core.sv
rtl/lsmab_checker.sv
tb/sv/testbench.sv
